// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker of the project.
// Stand-alone header; relies on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after the condition is seen.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  `ASSERT_CLK(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

// ===== rtl/rtfp_pkg.sv =====
// Shared constants, types and helpers of the radar target frame parser.
// No dependencies; compiled before every other file of the block.
package rtfp_pkg;

  localparam int unsigned PAYLOAD_LEN = 24;
  localparam int unsigned PAY_CNT_W   = 5;
  localparam int unsigned SLOT_BYTES  = 8;
  localparam int unsigned SLOT_BITS   = SLOT_BYTES * 8;
  localparam int unsigned NUM_TARGETS = 3;

  localparam logic [7:0] HDR_B0  = 8'hAA;
  localparam logic [7:0] HDR_B1  = 8'hFF;
  localparam logic [7:0] HDR_B2  = 8'h03;
  localparam logic [7:0] HDR_B3  = 8'h00;
  localparam logic [7:0] TAIL_B0 = 8'h55;
  localparam logic [7:0] TAIL_B1 = 8'hCC;

  localparam logic [16:0] HALF_RANGE = 17'd32768;

  // One raw 8-byte target slot with its position in the frame.
  typedef struct packed {
    logic [1:0]           idx;
    logic [SLOT_BITS-1:0] raw;
  } rtfp_slot_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      default: b = HDR_B3;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rtfp_byte_if.sv =====
// Byte channel of the frame parser: valid/ready handshake and one received byte.
// No dependencies.
interface rtfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rtfp_target_if.sv =====
// Target result channel of the frame parser: valid/ready handshake and one target.
// No dependencies.
interface rtfp_target_if;
  logic               valid;
  logic               ready;
  logic [1:0]         target_index;
  logic signed [15:0] x_mm;
  logic signed [15:0] y_mm;
  logic signed [15:0] speed;
  logic [15:0]        resolution;
  logic [15:0]        distance_mm;
  logic               last;

  modport source (output valid, output target_index, output x_mm, output y_mm,
                  output speed, output resolution, output distance_mm, output last,
                  input ready);
  modport sink   (input valid, input target_index, input x_mm, input y_mm,
                  input speed, input resolution, input distance_mm, input last,
                  output ready);
endinterface

// ===== rtl/radar_target_frame_parser_top.sv =====
// Radar target frame parser: takes one byte per cycle when ready is high. The
// front end gathers groups of four header bytes (AA FF 03 00, a wrong group is
// dropped whole), shifts in 24 payload bytes and checks the tail 55 CC; any
// wrong tail byte goes back to header search. On the closing CC the input
// drops ready while the three 8-byte target slots are queued (longer while the
// slot queue is full). The back end then turns each slot into one target
// result, using a 16-step bit-pair square root for the distance. A finished
// result waits in the output register while the next target is computed.
module radar_target_frame_parser_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtfp_byte_if.sink     rx_i,
  rtfp_target_if.source tgt_o
);
  import rtfp_pkg::*;

  // Slot hand-off between front and back.
  rtfp_slot_t push_data, pop_data;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;

  // Parse the byte stream and queue finished target slots.
  rtfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the frame parser from the slower target math.
  rtfp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Decode each slot, compute the distance and drive the result channel.
  rtfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .tgt_o       (tgt_o)
  );

endmodule

// ===== rtl/rtfp_fifo.sv =====
// Short slot queue between the frame front end and the target back end.
// Depends on rtfp_pkg for the slot type.
module rtfp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rtfp_pkg::rtfp_slot_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rtfp_pkg::rtfp_slot_t pop_data_o
);
  import rtfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rtfp_slot_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/rtfp_front.sv =====
// Frame front end: header check, payload capture, tail check, slot queuing.
// Depends on rtfp_pkg and the rtfp_byte_if interface.
module rtfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rtfp_byte_if.sink            rx_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output rtfp_pkg::rtfp_slot_t push_data_o
);
  import rtfp_pkg::*;

  typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_TAIL} phase_e;

  phase_e               phase_q, phase_d;
  logic [1:0]           hcnt_q, hcnt_d;
  logic                 match_q, match_d;
  logic [PAY_CNT_W-1:0] pcnt_q, pcnt_d;
  logic                 seen_q, seen_d;
  logic                 push_act_q, push_act_d;
  logic [1:0]           push_idx_q, push_idx_d;
  logic [7:0]           pay_q [PAYLOAD_LEN];
  logic [SLOT_BITS-1:0] slot_raw;
  logic                 accept, do_push, hdr_ok;
  logic [7:0]           b;

  assign rx_i.ready = !push_act_q;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign do_push    = push_act_q && push_ready_i;
  // Running match over the current group of four; the first byte restarts it.
  assign hdr_ok     = ((hcnt_q == 2'd0) ? 1'b1 : match_q) && (b == hdr_byte(hcnt_q));

  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    match_d    = match_q;
    pcnt_d     = pcnt_q;
    seen_d     = seen_q;
    push_act_d = push_act_q;
    push_idx_d = push_idx_q;

    if (accept) begin
      case (phase_q)
        PH_PAY: begin
          if (pcnt_q == PAY_CNT_W'(PAYLOAD_LEN - 1)) begin
            pcnt_d  = '0;
            seen_d  = 1'b0;
            phase_d = PH_TAIL;
          end else begin
            pcnt_d = pcnt_q + 1'b1;
          end
        end
        PH_TAIL: begin
          if (!seen_q && b == TAIL_B0) begin
            seen_d = 1'b1;
          end else begin
            seen_d  = 1'b0;
            hcnt_d  = '0;
            phase_d = PH_HDR;
            if (seen_q && b == TAIL_B1) begin
              push_act_d = 1'b1;
              push_idx_d = '0;
            end
          end
        end
        default: begin
          phase_d = PH_HDR;
          match_d = hdr_ok;
          hcnt_d  = hcnt_q + 1'b1;
          if (hcnt_q == 2'd3 && hdr_ok) begin
            pcnt_d  = '0;
            seen_d  = 1'b0;
            phase_d = PH_PAY;
          end
        end
      endcase
    end

    // Queue the three slots, then release the input again.
    if (do_push) begin
      if (push_idx_q == 2'(NUM_TARGETS - 1)) begin
        push_act_d = 1'b0;
      end else begin
        push_idx_d = push_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      hcnt_q     <= '0;
      match_q    <= 1'b0;
      pcnt_q     <= '0;
      seen_q     <= 1'b0;
      push_act_q <= 1'b0;
      push_idx_q <= '0;
    end else begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      match_q    <= match_d;
      pcnt_q     <= pcnt_d;
      seen_q     <= seen_d;
      push_act_q <= push_act_d;
      push_idx_q <= push_idx_d;
    end
  end

  // Payload shift line: after 24 bytes the first one sits at entry 0.
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_PAY) begin
      for (int i = 0; i < PAYLOAD_LEN - 1; i++) begin
        pay_q[i] <= pay_q[i+1];
      end
      pay_q[PAYLOAD_LEN-1] <= b;
    end
  end

  always_comb begin
    slot_raw = '0;
    for (int k = 0; k < SLOT_BYTES; k++) begin
      case (push_idx_q)
        2'd0:    slot_raw[8*k +: 8] = pay_q[k];
        2'd1:    slot_raw[8*k +: 8] = pay_q[SLOT_BYTES + k];
        default: slot_raw[8*k +: 8] = pay_q[2*SLOT_BYTES + k];
      endcase
    end
  end

  assign push_valid_o    = push_act_q;
  assign push_data_o.idx = push_idx_q;
  assign push_data_o.raw = slot_raw;

endmodule

// ===== rtl/rtfp_back.sv =====
// Target back end: word decode, squares, bit-pair square root, output register.
// Depends on rtfp_pkg and the rtfp_target_if interface.
module rtfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  rtfp_pkg::rtfp_slot_t pop_data_i,
  rtfp_target_if.source        tgt_o
);
  import rtfp_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MULX, ST_MULY, ST_ADD, ST_ROOT, ST_DONE} state_e;

  state_e             state_q;
  logic [1:0]         idx_q;
  logic signed [15:0] x_q, y_q, sp_q;
  logic [15:0]        resw_q, ax_q, ay_q;
  logic [31:0]        sqx_q, sqy_q, n_q, res_q, bit_q;

  logic               out_valid_q;
  logic [1:0]         o_idx_q;
  logic signed [15:0] o_x_q, o_y_q, o_sp_q;
  logic [15:0]        o_res_q, o_dist_q;
  logic               o_last_q;

  logic [15:0]        w0, w1, w2, w3;
  logic [15:0]        x_dec, y_dec, sp_dec, ay_dec;
  logic [31:0]        trial;
  logic               out_load;

  assign w0 = pop_data_i.raw[15:0];
  assign w1 = pop_data_i.raw[31:16];
  assign w2 = pop_data_i.raw[47:32];
  assign w3 = pop_data_i.raw[63:48];

  // x and speed: bit 15 set gives a positive magnitude in the low bits; clear, the word negated.
  assign x_dec  = w0[15] ? {1'b0, w0[14:0]} : 16'(17'd0 - {1'b0, w0});
  assign sp_dec = w2[15] ? {1'b0, w2[14:0]} : 16'(17'd0 - {1'b0, w2});
  assign y_dec  = {~w1[15], w1[14:0]};
  assign ay_dec = w1[15] ? {1'b0, w1[14:0]} : 16'(HALF_RANGE - {1'b0, w1});

  assign pop_ready_o = (state_q == ST_IDLE);
  assign trial       = res_q + bit_q;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || tgt_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      sp_q        <= '0;
      resw_q      <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      sqx_q       <= '0;
      sqy_q       <= '0;
      n_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      o_idx_q     <= '0;
      o_x_q       <= '0;
      o_y_q       <= '0;
      o_sp_q      <= '0;
      o_res_q     <= '0;
      o_dist_q    <= '0;
      o_last_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            idx_q   <= pop_data_i.idx;
            x_q     <= x_dec;
            y_q     <= y_dec;
            sp_q    <= sp_dec;
            resw_q  <= w3;
            ax_q    <= {1'b0, w0[14:0]};
            ay_q    <= ay_dec;
            state_q <= ST_MULX;
          end
        end
        ST_MULX: begin
          sqx_q   <= ax_q * ax_q;
          state_q <= ST_MULY;
        end
        ST_MULY: begin
          sqy_q   <= ay_q * ay_q;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          n_q     <= sqx_q + sqy_q;
          res_q   <= '0;
          bit_q   <= 32'h4000_0000;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          // One result bit per step, top bit pair first.
          if (n_q >= trial) begin
            n_q   <= n_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 32'd1) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
        o_idx_q     <= idx_q;
        o_x_q       <= x_q;
        o_y_q       <= y_q;
        o_sp_q      <= sp_q;
        o_res_q     <= resw_q;
        o_dist_q    <= res_q[15:0];
        o_last_q    <= (idx_q == 2'(NUM_TARGETS - 1));
      end else if (tgt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign tgt_o.valid        = out_valid_q;
  assign tgt_o.target_index = o_idx_q;
  assign tgt_o.x_mm         = o_x_q;
  assign tgt_o.y_mm         = o_y_q;
  assign tgt_o.speed        = o_sp_q;
  assign tgt_o.resolution   = o_res_q;
  assign tgt_o.distance_mm  = o_dist_q;
  assign tgt_o.last         = o_last_q;

endmodule

// ===== rtl/rtfp_checker.sv =====
// Port-level checks on the target result channel of the frame parser.
// Depends on assert_macros.svh; bound to radar_target_frame_parser_top below.
`include "assert_macros.svh"

module rtfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               ready_i,
  input logic [1:0]         target_index_i,
  input logic signed [15:0] x_mm_i,
  input logic signed [15:0] y_mm_i,
  input logic signed [15:0] speed_i,
  input logic [15:0]        resolution_i,
  input logic [15:0]        distance_mm_i,
  input logic               last_i
);
  logic signed [16:0] xs, ys;
  logic [16:0]        ax, ay, dist_ext;
  logic [82:0]        res_bus;
  logic               last_ok, dist_ok;

  assign xs       = 17'(x_mm_i);
  assign ys       = 17'(y_mm_i);
  assign ax       = (xs < 0) ? 17'(-xs) : 17'(xs);
  assign ay       = (ys < 0) ? 17'(-ys) : 17'(ys);
  assign dist_ext = {1'b0, distance_mm_i};
  assign last_ok  = (last_i == (target_index_i == 2'd2));
  assign dist_ok  = (dist_ext >= ax) && (dist_ext >= ay);
  assign res_bus  = {target_index_i, x_mm_i, y_mm_i, speed_i,
                     resolution_i, distance_mm_i, last_i};

  `ASSERT_CLK(a_last_on_third, clk_i, rst_ni, valid_i |-> last_ok, "last flag off the third target")
  `ASSERT_CLK(a_dist_bound, clk_i, rst_ni, valid_i |-> dist_ok, "distance below a magnitude")
  `ASSERT_CLK(a_valid_hold, clk_i, rst_ni, (valid_i && !ready_i) |=> valid_i, "result dropped")
  `ASSERT_HOLD(a_data_hold, clk_i, rst_ni, valid_i && !ready_i, res_bus, "result changed in stall")

endmodule

bind radar_target_frame_parser_top rtfp_checker u_rtfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (tgt_o.valid),
  .ready_i        (tgt_o.ready),
  .target_index_i (tgt_o.target_index),
  .x_mm_i         (tgt_o.x_mm),
  .y_mm_i         (tgt_o.y_mm),
  .speed_i        (tgt_o.speed),
  .resolution_i   (tgt_o.resolution),
  .distance_mm_i  (tgt_o.distance_mm),
  .last_i         (tgt_o.last)
);

// ===== dv/radar_target_frame_parser_checker.sv =====
// Checker for the radar target frame parser: watches both channels, predicts targets.
// Depends on rtfp_pkg, rtfp_byte_if and rtfp_target_if.
module radar_target_frame_parser_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  rtfp_byte_if   rx_mon,
  rtfp_target_if tgt_mon,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtfp_pkg::*;

  typedef enum logic [1:0] {
    SEEK_HEADER  = 2'd0,
    TAKE_PAYLOAD = 2'd1,
    TAKE_TAIL    = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] spd;
    logic [15:0] res;
    logic [15:0] dist_mm;
    logic        last;
  } target_t;

  parse_phase_e phase_q   = SEEK_HEADER;
  logic [7:0]   hdr_group [4];
  logic [2:0]   hdr_cnt   = '0;
  logic [7:0]   payload   [PAYLOAD_LEN];
  logic [4:0]   pay_cnt   = '0;
  logic         saw_tail0 = 1'b0;
  target_t      decoded_targets_q [$];
  int           mismatches = 0;

  assign fail_count_o = mismatches;

  // Floor square root, one result bit per step from the top.
  function automatic logic [15:0] isqrt_floor(input logic [31:0] n);
    logic [15:0] r;
    logic [15:0] c;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      c = r | (16'd1 << i);
      if ({16'b0, c} * {16'b0, c} <= n) r = c;
    end
    return r;
  endfunction

  // Sign-magnitude word: bit 15 set means positive.
  function automatic logic [15:0] sm_word(input logic [15:0] w);
    return w[15] ? {1'b0, w[14:0]} : 16'd0 - w;
  endfunction

  function automatic logic [31:0] mag_sq(input logic [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'd0 - v : v;
    return {16'b0, m} * {16'b0, m};
  endfunction

  function automatic target_t decode_slot(input int unsigned t);
    target_t     tg;
    int unsigned base;
    base       = t * SLOT_BYTES;
    tg.idx     = 2'(t);
    tg.x       = sm_word({payload[base+1], payload[base]});
    tg.y       = {~payload[base+3][7], payload[base+3][6:0], payload[base+2]};
    tg.spd     = sm_word({payload[base+5], payload[base+4]});
    tg.res     = {payload[base+7], payload[base+6]};
    tg.dist_mm = isqrt_floor(mag_sq(tg.x) + mag_sq(tg.y));
    tg.last    = (t == NUM_TARGETS - 1);
    return tg;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    case (phase_q)
      TAKE_PAYLOAD: begin
        payload[pay_cnt] = b;
        pay_cnt++;
        if (pay_cnt == PAYLOAD_LEN) begin
          pay_cnt   = '0;
          saw_tail0 = 1'b0;
          phase_q   = TAKE_TAIL;
        end
      end
      TAKE_TAIL: begin
        if (!saw_tail0 && b == TAIL_B0) begin
          saw_tail0 = 1'b1;
        end else begin
          // Closing byte releases the frame; anything else drops it.
          if (saw_tail0 && b == TAIL_B1) begin
            for (int t = 0; t < NUM_TARGETS; t++) decoded_targets_q.push_back(decode_slot(t));
          end
          saw_tail0 = 1'b0;
          hdr_cnt   = '0;
          phase_q   = SEEK_HEADER;
        end
      end
      default: begin
        phase_q = SEEK_HEADER;
        hdr_group[hdr_cnt[1:0]] = b;
        hdr_cnt++;
        if (hdr_cnt == 3'd4) begin
          hdr_cnt = '0;
          if (hdr_group[0] == HDR_B0 && hdr_group[1] == HDR_B1 &&
              hdr_group[2] == HDR_B2 && hdr_group[3] == HDR_B3) begin
            pay_cnt   = '0;
            saw_tail0 = 1'b0;
            phase_q   = TAKE_PAYLOAD;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input logic [1:0] idx, input string name,
                             input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: target %0d %s expected 0x%h, got 0x%h", $time, idx, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_target();
    target_t want;
    if (decoded_targets_q.size() == 0) begin
      $display("%0t: unexpected target result, index %0d x_mm 0x%h", $time,
               tgt_mon.target_index, tgt_mon.x_mm);
      mismatches++;
    end else begin
      want = decoded_targets_q.pop_front();
      check_field(want.idx, "target_index", 16'(want.idx), 16'(tgt_mon.target_index));
      check_field(want.idx, "x_mm", want.x, tgt_mon.x_mm);
      check_field(want.idx, "y_mm", want.y, tgt_mon.y_mm);
      check_field(want.idx, "speed", want.spd, tgt_mon.speed);
      check_field(want.idx, "resolution", want.res, tgt_mon.resolution);
      check_field(want.idx, "distance_mm", want.dist_mm, tgt_mon.distance_mm);
      check_field(want.idx, "last", 16'(want.last), 16'(tgt_mon.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_targets_q.delete();
      phase_q   = SEEK_HEADER;
      hdr_cnt   = '0;
      pay_cnt   = '0;
      saw_tail0 = 1'b0;
      pending_o <= 0;
    end else begin
      if (tgt_mon.valid && tgt_mon.ready) compare_target();
      if (rx_mon.valid && rx_mon.ready) parse_byte(rx_mon.rx_byte);
      pending_o <= decoded_targets_q.size();
    end
  end

endmodule

// ===== dv/radar_target_frame_parser_top_tb.sv =====
// Top of the frame parser testbench: clock, reset, byte stimulus, result
// back-pressure, watchdog and verdict. Depends on rtfp_pkg, both channel
// interfaces, the parser RTL and radar_target_frame_parser_checker.
module radar_target_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtfp_pkg::*;

  // Quiet cycles allowed: a frame's results come after the back-end math on its tail,
  // and each one may sit behind a long receiver stall.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last expected target, well past the back end latency.
  localparam int DRAIN_CYCLES   = 200;
  localparam int RAND_BYTES     = 500;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rtfp_byte_if   rx_if ();
  rtfp_target_if tgt_if ();

  int fail_count;
  int targets_pending;
  int rx_idle_pct   = 0;
  int tgt_stall_pct = 0;
  int bytes_sent    = 0;
  int quiet_cycles  = 0;

  logic [7:0]  hdr_bytes [4] = '{HDR_B0, HDR_B1, HDR_B2, HDR_B3};
  logic [7:0]  frame_payload [PAYLOAD_LEN];
  // Corner words per slot: x, y, speed, resolution.
  // Slot 0: zero distance and zero speed; slot 1: all ones but speed 7FFF;
  // slot 2: most negative x and y, giving the largest distance.
  logic [15:0] corner_words [12] = '{
    16'h8000, 16'h8000, 16'h0000, 16'h0000,
    16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
    16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000
  };

  always #1 clk_i = ~clk_i;

  radar_target_frame_parser_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tgt_o  (tgt_if)
  );

  radar_target_frame_parser_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_mon       (rx_if),
    .tgt_mon      (tgt_if),
    .fail_count_o (fail_count),
    .pending_o    (targets_pending)
  );

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk_i) begin
    tgt_if.ready <= ($urandom_range(99) >= tgt_stall_pct);
  end

  // Count cycles without any handshake; bail out when the block hangs.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (tgt_if.valid && tgt_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("radar_target_frame_parser_top verification failed");
      $finish;
    end
  end

  // Offer one byte, idling first at the current rate, and hold it until taken.
  // Valid gets exactly one assignment per clock step.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < rx_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Fill the payload with random words, corner values mixed in.
  task automatic fill_payload();
    logic [15:0] w;
    for (int k = 0; k < PAYLOAD_LEN / 2; k++) begin
      case ($urandom_range(7))
        0:       w = 16'h0000;
        1:       w = 16'h7FFF;
        2:       w = 16'h8000;
        3:       w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      frame_payload[2*k]   = w[7:0];
      frame_payload[2*k+1] = w[15:8];
    end
  endtask

  // Header, the staged payload, then one or two tail bytes.
  task automatic send_frame(input int n_tail, input logic [7:0] t0, input logic [7:0] t1);
    for (int i = 0; i < 4; i++) push_byte(hdr_bytes[i]);
    for (int i = 0; i < PAYLOAD_LEN; i++) push_byte(frame_payload[i]);
    push_byte(t0);
    if (n_tail > 1) push_byte(t1);
  endtask

  initial begin
    int         iter;
    int         pick;
    logic [7:0] b;
    logic [7:0] grp [4];

    iter        = 0;
    // Known values on every block input from time zero.
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    tgt_if.ready  = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed part, no idling ----------------
    // Frame of corner words: zero, all-ones, largest distance.
    for (int k = 0; k < 12; k++) begin
      frame_payload[2*k]   = corner_words[k][7:0];
      frame_payload[2*k+1] = corner_words[k][15:8];
    end
    send_frame(2, TAIL_B0, TAIL_B1);

    // A header shifted by one byte must be lost: groups are dropped whole.
    push_byte(8'h11);
    for (int i = 0; i < 3; i++) push_byte(hdr_bytes[i]);
    push_byte(hdr_bytes[3]);
    for (int i = 0; i < 3; i++) push_byte(hdr_bytes[i]);
    // Near-miss header group.
    for (int i = 0; i < 3; i++) push_byte(hdr_bytes[i]);
    push_byte(8'h01);

    // Wrong first tail byte, a repeated 55, and a wrong closing byte.
    fill_payload();
    send_frame(1, TAIL_B1, 8'h00);
    fill_payload();
    send_frame(2, TAIL_B0, TAIL_B0);
    fill_payload();
    send_frame(2, TAIL_B0, HDR_B0);

    // Recovery: a clean frame right after the broken ones.
    fill_payload();
    send_frame(2, TAIL_B0, TAIL_B1);

    // ---------------- random part ----------------
    while (bytes_sent < RAND_BYTES) begin
      // Cycle through the idling phases every six iterations.
      case ((iter / 6) % 4)
        0:       begin rx_idle_pct = 0;  tgt_stall_pct = 0;  end
        1:       begin rx_idle_pct = 58; tgt_stall_pct = 0;  end
        2:       begin rx_idle_pct = 0;  tgt_stall_pct = 58; end
        default: begin rx_idle_pct = 11; tgt_stall_pct = 11; end
      endcase
      iter++;
      pick = $urandom_range(99);
      if (pick < 68) begin
        // Well-formed frame with random content.
        fill_payload();
        send_frame(2, TAIL_B0, TAIL_B1);
      end else if (pick < 84) begin
        // One header-sized group of noise: a near miss or plain random bytes.
        for (int i = 0; i < 4; i++) grp[i] = hdr_bytes[i];
        if ($urandom_range(1)) begin
          grp[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end else begin
          for (int i = 0; i < 4; i++) grp[i] = 8'($urandom);
        end
        for (int i = 0; i < 4; i++) push_byte(grp[i]);
      end else begin
        // Frame that dies in its tail.
        fill_payload();
        if ($urandom_range(1)) begin
          b = 8'($urandom);
          if (b == TAIL_B0) b = TAIL_B1;
          send_frame(1, b, 8'h00);
        end else begin
          b = $urandom_range(1) ? TAIL_B0 : 8'($urandom);
          if (b == TAIL_B1) b = TAIL_B0;
          send_frame(2, TAIL_B0, b);
        end
      end
    end
    rx_if.valid <= 1'b0;

    // Drain: let the checker see the last item, then wait out the results.
    @(posedge clk_i);
    while (targets_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("radar_target_frame_parser_top verification clean");
    end else begin
      $display("radar_target_frame_parser_top verification failed");
    end
    $finish;
  end

endmodule
